### sv/pps_pkg.sv
// Shared types and constants of the priority process scheduler.
package pps_pkg;

	localparam int IdW       = 7;
	localparam int PriW      = 4;
	localparam int BlkW      = 3;
	localparam int NeedW     = 5;
	localparam int QuW       = 3;
	localparam int LimW      = 5;
	localparam int MaskW     = 16;
	localparam int CfgDataW  = 7;
	localparam int CfgIdxW   = 2;
	localparam int CountOutW = 5;
	localparam int NextIdW   = 8;

	typedef enum logic [1:0] {
		MODE_READY   = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_BLOCKED = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FULL_QUANTUM  = 2'd0,
		CFG_PROCESS_LIMIT = 2'd1,
		CFG_LAST_ID       = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [IdW-1:0]   id;
		logic [PriW-1:0]  pri;   // two's complement
		mode_t            mode;
		logic [BlkW-1:0]  blk;
		logic [NeedW-1:0] need;
		logic [NeedW-1:0] used;
		logic [QuW-1:0]   qu;
	} entry_t;

	// what the entry under the scan pointer is tested for
	typedef enum logic [2:0] {
		SC_DONE     = 3'd0,
		SC_QUOTA    = 3'd1,
		SC_PLACE    = 3'd2,
		SC_READY    = 3'd3,
		SC_RUNNING  = 3'd4,
		SC_SLOT_NEW = 3'd5
	} scan_t;

	typedef struct packed {
		logic  load_in;
		logic  clear_k;
		logic  step_k;
		scan_t scan;
		logic  remove_k;
		logic  requeue_k;
		logic  insert_k;
		logic  run_k;
		logic  charge_k;
		logic  unblock;
		logic  create_t;
		logic  emit;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic at_end;
		logic create_ok;
		logic runner;
		logic out_busy;
	} dp_stat_t;

endpackage

### sv/pps_if.sv
// Tick and report channel interfaces.
interface pps_tick_if import pps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             create_request;
	logic [BlkW-1:0]  new_block_limit;
	logic [NeedW-1:0] new_cpu_need;
	logic [MaskW-1:0] unblock_mask;

	modport source(output valid, create_request, new_block_limit, new_cpu_need,
		unblock_mask, input ready);
	modport sink(input valid, create_request, new_block_limit, new_cpu_need,
		unblock_mask, output ready);
endinterface

interface pps_report_if import pps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [IdW-1:0]        running_id;
	logic                  finished_flag;
	logic [IdW-1:0]        finished_id;
	logic                  requeued_flag;
	logic [IdW-1:0]        requeued_id;
	logic signed [PriW-1:0] requeued_priority;
	logic [IdW-1:0]        created_id;
	logic [CountOutW-1:0]  process_count;
	logic                  ids_exhausted;

	modport source(output valid, running_id, finished_flag, finished_id, requeued_flag,
		requeued_id, requeued_priority, created_id, process_count, ids_exhausted,
		input ready);
	modport sink(input valid, running_id, finished_flag, finished_id, requeued_flag,
		requeued_id, requeued_priority, created_id, process_count, ids_exhausted,
		output ready);
endinterface

### sv/pps_datapath.sv
// Process table, scan pointer, result registers and configuration of the scheduler.
module pps_datapath import pps_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	output dp_stat_t                     stat,
	input  logic                         cfg_we,
	input  logic [CfgIdxW-1:0]           cfg_idx,
	input  logic [CfgDataW-1:0]          cfg_data,
	input  logic                         create_request,
	input  logic [BlkW-1:0]              new_block_limit,
	input  logic [NeedW-1:0]             new_cpu_need,
	input  logic [MaskW-1:0]             unblock_mask,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [IdW-1:0]               running_id,
	output logic                         finished_flag,
	output logic [IdW-1:0]               finished_id,
	output logic                         requeued_flag,
	output logic [IdW-1:0]               requeued_id,
	output logic signed [PriW-1:0]       requeued_priority,
	output logic [IdW-1:0]               created_id,
	output logic [CountOutW-1:0]         process_count,
	output logic                         ids_exhausted
);

	localparam int IW       = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW       = $clog2(TABLE_SLOTS + 1);
	localparam int CmpW     = (CW > LimW) ? CW : LimW;
	localparam int MaskPadW = (TABLE_SLOTS > MaskW) ? TABLE_SLOTS : MaskW;

	entry_t                slots_q [TABLE_SLOTS];
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         k_q;
	logic                  runner_q;
	logic [NextIdW-1:0]    next_id_q;
	logic [BlkW-1:0]       full_quantum_q;
	logic [LimW-1:0]       process_limit_q;
	logic [IdW-1:0]        last_id_q;
	entry_t                t_q;
	logic                  create_q;
	logic [BlkW-1:0]       nblk_q;
	logic [NeedW-1:0]      nneed_q;
	logic [MaskW-1:0]      mask_q;
	logic [IdW-1:0]        run_id_q;
	logic                  fin_flag_q;
	logic [IdW-1:0]        fin_id_q;
	logic                  rq_flag_q;
	logic [IdW-1:0]        rq_id_q;
	logic [PriW-1:0]       rq_pri_q;
	logic [IdW-1:0]        cr_id_q;
	logic                  out_valid_q;

	entry_t                cur;
	logic [PriW-1:0]       mag_cur;
	logic [PriW-1:0]       mag_t;
	logic [CountOutW-1:0]  pri_sum;
	logic [PriW-1:0]       pri_half;
	logic [PriW-1:0]       pri_sat;
	logic [PriW-1:0]       pri_new;
	logic                  place_go;
	logic                  take;
	logic [MaskPadW-1:0]   mask_pad;
	entry_t                requeued;
	entry_t                created;

	assign cur     = slots_q[k_q[IW-1:0]];
	assign mag_cur = cur.pri[PriW-1] ? (~cur.pri + 1'b1) : cur.pri;
	assign mag_t   = t_q.pri[PriW-1] ? (~t_q.pri + 1'b1) : t_q.pri;

	// ceil((|p| + q) / 2), saturated at seven, negated if blk is not the full quantum
	assign pri_sum  = CountOutW'(mag_cur) + CountOutW'(cur.qu) + CountOutW'(1);
	assign pri_half = pri_sum[CountOutW-1:1];
	assign pri_sat  = (pri_half > PriW'(7)) ? PriW'(7) : pri_half;
	assign pri_new  = (cur.blk != full_quantum_q) ? (~pri_sat + 1'b1) : pri_sat;

	always_comb begin
		if (!t_q.pri[PriW-1]) begin
			place_go = cur.pri[PriW-1] || (mag_t >= cur.pri);
		end else begin
			place_go = cur.pri[PriW-1] && (mag_t >= mag_cur);
		end
	end

	always_comb begin
		requeued      = cur;
		requeued.pri  = pri_new;
		requeued.mode = pri_new[PriW-1] ? MODE_BLOCKED : MODE_READY;
		requeued.qu   = '0;
		created.id    = next_id_q[IdW-1:0];
		created.pri   = '0;
		created.mode  = MODE_READY;
		created.blk   = nblk_q;
		created.need  = nneed_q;
		created.used  = '0;
		created.qu    = '0;
	end

	always_comb begin
		stat.at_end    = (k_q >= count_q);
		stat.runner    = runner_q;
		stat.out_busy  = out_valid_q && !out_ready;
		stat.create_ok = create_q && (next_id_q <= NextIdW'(last_id_q)) &&
			(CmpW'(count_q) < CmpW'(process_limit_q)) && (count_q < CW'(TABLE_SLOTS));
		unique case (cmd.scan)
			SC_DONE:     stat.hit = (cur.used == cur.need);
			SC_QUOTA:    stat.hit = (cur.qu == cur.blk);
			SC_PLACE:    stat.hit = !place_go;
			SC_READY:    stat.hit = (cur.mode == MODE_READY);
			SC_RUNNING:  stat.hit = (cur.mode == MODE_RUNNING);
			SC_SLOT_NEW: stat.hit = !cur.pri[PriW-1] && (cur.pri != '0);
			default:     stat.hit = 1'b0;
		endcase
	end

	assign take     = cmd.remove_k || cmd.requeue_k;
	assign mask_pad = MaskPadW'(mask_q);

	for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
		entry_t upper;
		entry_t lower;
		logic   at_k;
		logic   past_k;

		if (g == TABLE_SLOTS - 1) begin : g_top
			assign upper = slots_q[g];
		end else begin : g_mid
			assign upper = slots_q[g+1];
		end
		if (g == 0) begin : g_bot
			assign lower = t_q;
		end else begin : g_low
			assign lower = slots_q[g-1];
		end

		assign at_k   = (CW'(g) == k_q);
		assign past_k = (CW'(g) > k_q);

		always_ff @(posedge clk) begin
			if (take) begin
				if (at_k || past_k) begin
					slots_q[g] <= upper;
				end
			end else if (cmd.insert_k) begin
				if (past_k) begin
					slots_q[g] <= lower;
				end else if (at_k) begin
					slots_q[g] <= t_q;
				end
			end else if (cmd.run_k && at_k) begin
				slots_q[g].mode <= MODE_RUNNING;
			end else if (cmd.charge_k && at_k) begin
				slots_q[g].used <= slots_q[g].used + 1'b1;
				slots_q[g].qu   <= slots_q[g].qu + 1'b1;
			end else if (cmd.unblock) begin
				if ((g < MaskW) && (CW'(g) < count_q) && mask_pad[g] &&
					(slots_q[g].mode == MODE_BLOCKED)) begin
					slots_q[g].mode <= MODE_READY;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= '0;
			k_q             <= '0;
			runner_q        <= 1'b0;
			next_id_q       <= NextIdW'(1);
			full_quantum_q  <= BlkW'(6);
			process_limit_q <= LimW'(10);
			last_id_q       <= IdW'(100);
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_FULL_QUANTUM:  full_quantum_q  <= cfg_data[BlkW-1:0];
					CFG_PROCESS_LIMIT: process_limit_q <= cfg_data[LimW-1:0];
					CFG_LAST_ID:       last_id_q       <= cfg_data[IdW-1:0];
					default: ;
				endcase
			end
			if (cmd.clear_k) begin
				k_q <= '0;
			end else if (cmd.step_k) begin
				k_q <= k_q + 1'b1;
			end
			if (take) begin
				count_q  <= count_q - 1'b1;
				runner_q <= 1'b0;
			end else if (cmd.insert_k) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.run_k) begin
				runner_q <= 1'b1;
			end
			if (cmd.create_t) begin
				next_id_q <= next_id_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			create_q   <= create_request;
			nblk_q     <= new_block_limit;
			nneed_q    <= new_cpu_need;
			mask_q     <= unblock_mask;
			run_id_q   <= '0;
			fin_flag_q <= 1'b0;
			fin_id_q   <= '0;
			rq_flag_q  <= 1'b0;
			rq_id_q    <= '0;
			rq_pri_q   <= '0;
			cr_id_q    <= '0;
		end
		if (cmd.remove_k) begin
			fin_flag_q <= 1'b1;
			fin_id_q   <= cur.id;
		end
		if (cmd.requeue_k) begin
			rq_flag_q <= 1'b1;
			rq_id_q   <= cur.id;
			rq_pri_q  <= pri_new;
			t_q       <= requeued;
		end
		if (cmd.charge_k) begin
			run_id_q <= cur.id;
		end
		if (cmd.create_t) begin
			cr_id_q <= created.id;
			t_q     <= created;
		end
		if (cmd.emit) begin
			running_id        <= run_id_q;
			finished_flag     <= fin_flag_q;
			finished_id       <= fin_id_q;
			requeued_flag     <= rq_flag_q;
			requeued_id       <= rq_id_q;
			requeued_priority <= $signed(rq_pri_q);
			created_id        <= cr_id_q;
			process_count     <= CountOutW'(count_q);
			ids_exhausted     <= (next_id_q > NextIdW'(last_id_q));
		end
	end

	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_SLOTS))
		else $error("entry count above table size");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert_k && !take |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table");

	a_take_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> count_q == $past(count_q) - 1'b1 && !runner_q)
		else $error("removal did not shrink the table or clear the runner");

endmodule

### sv/pps_ctrl.sv
// Sequencer that walks the tick phases over the process table.
module pps_ctrl import pps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_REMOVE, S_REQUEUE, S_PLACE, S_DISPATCH, S_CHARGE,
		S_UNBLOCK, S_CREATE, S_NEW_PLACE, S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		cmd.scan = SC_DONE;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.clear_k = 1'b1;
					state_d     = S_REMOVE;
				end
			end
			S_REMOVE: begin
				cmd.scan = SC_DONE;
				if (stat.at_end || stat.hit) begin
					cmd.remove_k = !stat.at_end;
					cmd.clear_k  = 1'b1;
					state_d      = S_REQUEUE;
				end else begin
					cmd.step_k = 1'b1;
				end
			end
			S_REQUEUE: begin
				cmd.scan = SC_QUOTA;
				if (stat.at_end) begin
					cmd.clear_k = 1'b1;
					state_d     = S_DISPATCH;
				end else if (stat.hit) begin
					cmd.requeue_k = 1'b1;
					cmd.clear_k   = 1'b1;
					state_d       = S_PLACE;
				end else begin
					cmd.step_k = 1'b1;
				end
			end
			S_PLACE: begin
				cmd.scan = SC_PLACE;
				if (stat.at_end || stat.hit) begin
					cmd.insert_k = 1'b1;
					cmd.clear_k  = 1'b1;
					state_d      = S_DISPATCH;
				end else begin
					cmd.step_k = 1'b1;
				end
			end
			S_DISPATCH: begin
				cmd.scan = SC_READY;
				if (stat.runner || stat.at_end || stat.hit) begin
					cmd.run_k   = !stat.runner && !stat.at_end;
					cmd.clear_k = 1'b1;
					state_d     = S_CHARGE;
				end else begin
					cmd.step_k = 1'b1;
				end
			end
			S_CHARGE: begin
				cmd.scan = SC_RUNNING;
				if (stat.at_end || stat.hit) begin
					cmd.charge_k = !stat.at_end;
					state_d      = S_UNBLOCK;
				end else begin
					cmd.step_k = 1'b1;
				end
			end
			S_UNBLOCK: begin
				cmd.unblock = 1'b1;
				cmd.clear_k = 1'b1;
				state_d     = S_CREATE;
			end
			S_CREATE: begin
				if (stat.create_ok) begin
					cmd.create_t = 1'b1;
					state_d      = S_NEW_PLACE;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_NEW_PLACE: begin
				cmd.scan = SC_SLOT_NEW;
				if (stat.at_end || stat.hit) begin
					cmd.insert_k = 1'b1;
					state_d      = S_FINISH;
				end else begin
					cmd.step_k = 1'b1;
				end
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/priority_process_scheduler_core.sv
// Top level of the priority process scheduler.
// One tick beat advances the process table by one scheduler tick and yields one report
// beat. Removal, requeue, reinsertion, dispatch, charge and placement of a new
// process each walk the table one entry per cycle through a single scan pointer.
// A new tick is taken while the previous report still waits at the output register.
// No clearing pass after reset; configuration writes are taken at any time.
module priority_process_scheduler_core import pps_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	pps_tick_if.sink            tick,
	pps_report_if.source        report,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pps_datapath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_data          (cfg_data),
		.create_request    (tick.create_request),
		.new_block_limit   (tick.new_block_limit),
		.new_cpu_need      (tick.new_cpu_need),
		.unblock_mask      (tick.unblock_mask),
		.out_ready         (report.ready),
		.out_valid         (report.valid),
		.running_id        (report.running_id),
		.finished_flag     (report.finished_flag),
		.finished_id       (report.finished_id),
		.requeued_flag     (report.requeued_flag),
		.requeued_id       (report.requeued_id),
		.requeued_priority (report.requeued_priority),
		.created_id        (report.created_id),
		.process_count     (report.process_count),
		.ids_exhausted     (report.ids_exhausted)
	);

endmodule
